// ----- hw/rtl/usan_pkg.sv -----
// Shared types and constants for the UTF-8 stream sanitizer.
package usan_pkg;

    // Input word: one raw byte plus the end-of-stream mark
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_stream;
    } in_word_t;

    // Output word: one sanitized byte plus the last-of-run mark
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
    } out_word_t;

    // One emit unit: a literal byte or a full replacement character
    typedef struct packed {
        logic       is_rep;
        logic [7:0] data;
    } unit_t;

    localparam int unsigned MAX_UNITS = 4;

    // Work handed from the front to the back: up to four units, in order
    typedef struct packed {
        unit_t [MAX_UNITS-1:0] units;
        logic [2:0]            count;
    } cmd_t;

    // U+FFFD encoded
    localparam logic [7:0] REP_B0 = 8'hEF;
    localparam logic [7:0] REP_B1 = 8'hBF;
    localparam logic [7:0] REP_B2 = 8'hBD;

    // Scalar value limits
    localparam logic [20:0] CP_MIN_2B  = 21'h00080;
    localparam logic [20:0] CP_MIN_3B  = 21'h00800;
    localparam logic [20:0] CP_MIN_4B  = 21'h10000;
    localparam logic [20:0] CP_MAX     = 21'h10FFFF;
    localparam logic [20:0] SURR_LO    = 21'h0D800;
    localparam logic [20:0] SURR_HI    = 21'h0DFFF;

    // Sequence lengths
    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_2    = 3'd2;
    localparam logic [2:0] LEN_3    = 3'd3;
    localparam logic [2:0] LEN_4    = 3'd4;

endpackage

// ----- hw/rtl/usan_front.sv -----
// Front end: accepts bytes, tracks the open sequence, builds emit commands.
module usan_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              valid,
    output logic              ready,
    input  usan_pkg::in_word_t data,
    input  logic              q_full,
    output logic              push,
    output usan_pkg::cmd_t    cmd
);

    logic [2:0]  exp_reg, exp_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [7:0]  held_reg [3];
    logic        hold_we;
    logic [1:0]  hold_idx;
    logic        accept;
    logic [7:0]  b;
    logic        is_cont;
    logic        fresh;
    logic        finish;
    logic        bad;
    logic [20:0] cp;
    logic [7:0]  seq [4];
    logic [2:0]  n;

    assign ready  = !q_full;
    assign accept = valid && ready;
    assign b      = data.in_byte;
    assign is_cont = (b[7:6] == 2'b10);
    assign finish = (({1'b0, cnt_reg} + 3'd1) >= exp_reg) || (cnt_reg == 2'd3);

    // Assemble the complete sequence and decode its scalar value
    always_comb
    begin
        seq[0] = held_reg[0];
        seq[1] = (exp_reg == usan_pkg::LEN_2) ? b : held_reg[1];
        seq[2] = (exp_reg == usan_pkg::LEN_3) ? b : held_reg[2];
        seq[3] = b;
        case (exp_reg)
            usan_pkg::LEN_2:
                cp = {10'd0, held_reg[0][4:0], b[5:0]};
            usan_pkg::LEN_3:
                cp = {5'd0, held_reg[0][3:0], held_reg[1][5:0], b[5:0]};
            default:
                cp = {held_reg[0][2:0], held_reg[1][5:0], held_reg[2][5:0], b[5:0]};
        endcase
        bad = ((exp_reg == usan_pkg::LEN_2) && (cp < usan_pkg::CP_MIN_2B)) ||
              ((exp_reg == usan_pkg::LEN_3) && (cp < usan_pkg::CP_MIN_3B)) ||
              ((exp_reg == usan_pkg::LEN_4) && (cp < usan_pkg::CP_MIN_4B)) ||
              (cp > usan_pkg::CP_MAX) ||
              ((cp >= usan_pkg::SURR_LO) && (cp <= usan_pkg::SURR_HI));
    end

    // Classify the byte and build the ordered list of emit units
    always_comb
    begin
        cmd      = '0;
        n        = 3'd0;
        exp_next = exp_reg;
        cnt_next = cnt_reg;
        hold_we  = 1'b0;
        hold_idx = 2'd0;
        fresh    = 1'b1;

        if (exp_reg != usan_pkg::LEN_NONE)
        begin
            if (is_cont)
            begin
                fresh = 1'b0;
                if (finish)
                begin
                    for (int k = 0; k < 4; k++)
                    begin
                        if (3'(k) < exp_reg && n < 3'd4)
                        begin
                            cmd.units[n[1:0]].is_rep = bad;
                            cmd.units[n[1:0]].data   = bad ? 8'h00 : seq[k];
                            n = n + 3'd1;
                        end
                    end
                    exp_next = usan_pkg::LEN_NONE;
                    cnt_next = 2'd0;
                end
                else
                begin
                    hold_we  = 1'b1;
                    hold_idx = cnt_reg;
                    cnt_next = cnt_reg + 2'd1;
                end
            end
            else
            begin
                // interrupted: one replacement per held byte
                for (int k = 0; k < 3; k++)
                begin
                    if (2'(k) < cnt_reg && n < 3'd4)
                    begin
                        cmd.units[n[1:0]].is_rep = 1'b1;
                        n = n + 3'd1;
                    end
                end
                exp_next = usan_pkg::LEN_NONE;
                cnt_next = 2'd0;
            end
        end

        if (fresh)
        begin
            if (b inside {[8'h00:8'h7F]})
            begin
                if (n < 3'd4)
                begin
                    cmd.units[n[1:0]].is_rep = 1'b0;
                    cmd.units[n[1:0]].data   = b;
                    n = n + 3'd1;
                end
            end
            else if (b inside {[8'hC0:8'hF7]})
            begin
                hold_we  = 1'b1;
                hold_idx = 2'd0;
                cnt_next = 2'd1;
                if (b inside {[8'hC0:8'hDF]})
                    exp_next = usan_pkg::LEN_2;
                else if (b inside {[8'hE0:8'hEF]})
                    exp_next = usan_pkg::LEN_3;
                else
                    exp_next = usan_pkg::LEN_4;
            end
            else if (n < 3'd4)
            begin
                // stray continuation or invalid lead
                cmd.units[n[1:0]].is_rep = 1'b1;
                n = n + 3'd1;
            end
        end

        // end of stream: flush what is still held
        if (data.end_of_stream)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (2'(k) < cnt_next && n < 3'd4)
                begin
                    cmd.units[n[1:0]].is_rep = 1'b1;
                    n = n + 3'd1;
                end
            end
            exp_next = usan_pkg::LEN_NONE;
            cnt_next = 2'd0;
        end

        cmd.count = n;
    end

    assign push = accept && (n != 3'd0);

    // Sequence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_reg <= usan_pkg::LEN_NONE;
            cnt_reg <= 2'd0;
        end
        else if (accept)
        begin
            exp_reg <= exp_next;
            cnt_reg <= cnt_next;
        end
    end

    // Held bytes
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (accept && hold_we && hold_idx == 2'(i))
                held_reg[i] <= b;
        end
    end

endmodule

// ----- hw/rtl/usan_fifo.sv -----
// Short command queue between the front and back ends.
module usan_fifo #(
    parameter int unsigned DEPTH = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  usan_pkg::cmd_t push_data,
    input  logic           pop,
    output usan_pkg::cmd_t head,
    output logic           full,
    output logic           empty
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    usan_pkg::cmd_t mem_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    logic           do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ----- hw/rtl/usan_back.sv -----
// Back end: walks the head command and emits one output word per cycle while the receiver does not stall it.
module usan_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  usan_pkg::cmd_t       head,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output usan_pkg::out_word_t  out_data
);

    logic [1:0]          unit_idx_reg;
    logic [1:0]          sub_idx_reg;
    logic                valid_reg;
    usan_pkg::out_word_t data_reg;
    usan_pkg::unit_t     cur;
    logic [7:0]          cur_byte;
    logic                unit_last;
    logic                cmd_last;
    logic                emit;

    assign cur = head.units[unit_idx_reg];

    // Pick the byte of the current unit
    always_comb
    begin
        if (cur.is_rep)
        begin
            case (sub_idx_reg)
                2'd0:    cur_byte = usan_pkg::REP_B0;
                2'd1:    cur_byte = usan_pkg::REP_B1;
                default: cur_byte = usan_pkg::REP_B2;
            endcase
        end
        else
        begin
            cur_byte = cur.data;
        end
    end

    assign unit_last = !cur.is_rep || (sub_idx_reg == 2'd2);
    assign cmd_last  = unit_last && ({1'b0, unit_idx_reg} == (head.count - 3'd1));
    assign emit      = q_valid && (!valid_reg || out_ready);
    assign pop       = emit && cmd_last;

    // Walk position and output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_idx_reg <= 2'd0;
            sub_idx_reg  <= 2'd0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                valid_reg <= 1'b1;
                if (cmd_last)
                begin
                    unit_idx_reg <= 2'd0;
                    sub_idx_reg  <= 2'd0;
                end
                else if (unit_last)
                begin
                    unit_idx_reg <= unit_idx_reg + 2'd1;
                    sub_idx_reg  <= 2'd0;
                end
                else
                begin
                    sub_idx_reg <= sub_idx_reg + 2'd1;
                end
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            data_reg.out_byte <= cur_byte;
            data_reg.run_last <= cmd_last;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- hw/rtl/utf8_stream_sanitizer.sv -----
// An accepted byte's command is written to the queue, then the back end loads its first output word.
// Throughput: one input byte per cycle while each byte yields at most one output byte and the receiver
// takes every word; a byte that yields N output bytes (up to 12) holds the back end until all are out,
// and input stalls once the command queue of QUEUE_DEPTH entries is full.
// Reset: asynchronous, active low; clears sequence state, queue and output valid at once.
module utf8_stream_sanitizer #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  usan_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output usan_pkg::out_word_t out_data
);

    logic           q_push;
    logic           q_pop;
    logic           q_full;
    logic           q_empty;
    usan_pkg::cmd_t push_cmd;
    usan_pkg::cmd_t head_cmd;

    usan_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .valid  (in_valid),
        .ready  (in_ready),
        .data   (in_data),
        .q_full (q_full),
        .push   (q_push),
        .cmd    (push_cmd)
    );

    usan_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_cmd),
        .pop       (q_pop),
        .head      (head_cmd),
        .full      (q_full),
        .empty     (q_empty)
    );

    usan_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (!q_empty),
        .head      (head_cmd),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

`ifndef NO_ASSERTIONS
    // A pushed command always carries between one and four units
    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (push_cmd.count != 3'd0) && (push_cmd.count <= 3'd4))
        else $error("command with bad unit count pushed");

    // Output words only come from a queued command
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!q_empty))
        else $error("output word appeared with an empty queue");

    // Queue cannot be full and empty together
    assert property (@(posedge clk) disable iff (!rst_n)
        !(q_full && q_empty))
        else $error("queue full and empty at once");
`endif

endmodule

// ----- tb/utf8_stream_sanitizer_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for utf8_stream_sanitizer: directed table, a long output hold-off, then random byte streams.
module utf8_stream_sanitizer_test;

    localparam int RANDOM_WORDS = 385;
    localparam int CALM_WORDS   = 60;   // final stretch with no idling
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 16;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    usan_pkg::in_word_t  in_data;
    logic                out_valid;
    logic                out_ready;
    usan_pkg::out_word_t out_data;

    utf8_stream_sanitizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Directed row: input word and, where obvious, the exact output bytes
    typedef struct packed {
        logic [7:0]  b;
        logic        eos;
        logic        gold_on;
        logic [1:0]  gold_n;
        logic [23:0] gold;
    } dir_row_t;

    dir_row_t dir_tab [25] = '{
        {8'h00, 1'b0, 1'b1, 2'd1, 24'h00_0000},  // lowest ASCII
        {8'h7F, 1'b0, 1'b1, 2'd1, 24'h7F_0000},  // highest ASCII
        {8'h80, 1'b0, 1'b1, 2'd3, 24'hEF_BFBD},  // stray continuation
        {8'hBF, 1'b0, 1'b1, 2'd3, 24'hEF_BFBD},  // stray continuation
        {8'hFF, 1'b0, 1'b1, 2'd3, 24'hEF_BFBD},  // invalid lead
        {8'hF8, 1'b0, 1'b1, 2'd3, 24'hEF_BFBD},  // invalid lead
        {8'hC3, 1'b0, 1'b1, 2'd0, 24'h00_0000},  // lead opens a 2-byte sequence
        {8'hA9, 1'b0, 1'b0, 2'd0, 24'h00_0000},  // valid 2-byte
        {8'hC0, 1'b0, 1'b1, 2'd0, 24'h00_0000},
        {8'hAF, 1'b0, 1'b0, 2'd0, 24'h00_0000},  // overlong 2-byte
        {8'hED, 1'b0, 1'b1, 2'd0, 24'h00_0000},
        {8'hA0, 1'b0, 1'b0, 2'd0, 24'h00_0000},
        {8'h80, 1'b0, 1'b0, 2'd0, 24'h00_0000},  // surrogate
        {8'hF4, 1'b0, 1'b1, 2'd0, 24'h00_0000},
        {8'h90, 1'b0, 1'b0, 2'd0, 24'h00_0000},
        {8'h80, 1'b0, 1'b0, 2'd0, 24'h00_0000},
        {8'h80, 1'b0, 1'b0, 2'd0, 24'h00_0000},  // above 10FFFF, twelve bytes out
        {8'hE2, 1'b0, 1'b1, 2'd0, 24'h00_0000},
        {8'h41, 1'b0, 1'b0, 2'd0, 24'h00_0000},  // interrupted by ASCII
        {8'hF5, 1'b0, 1'b1, 2'd0, 24'h00_0000},
        {8'h8F, 1'b0, 1'b0, 2'd0, 24'h00_0000},
        {8'hBF, 1'b1, 1'b0, 2'd0, 24'h00_0000},  // end of stream flushes three held
        {8'hF0, 1'b0, 1'b1, 2'd0, 24'h00_0000},
        {8'h9F, 1'b0, 1'b0, 2'd0, 24'h00_0000},
        {8'h98, 1'b0, 1'b0, 2'd0, 24'h00_0000}
    };

    // Sanitizer state as seen by the predictor
    logic [7:0]          seq_hold [3];
    logic [2:0]          seq_len;
    logic [1:0]          seq_cnt;
    logic [7:0]          run_bytes [$];   // output bytes of the current input word
    usan_pkg::out_word_t exp_q [$];       // output words still to arrive
    usan_pkg::in_word_t  pending [$];     // random words not yet offered

    logic idle_on;
    logic rx_hold;
    int   errors;
    int   words_in;
    int   words_out;
    int   eos_count;

    // Clock
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // ---------------- predictor ----------------

    function automatic void emit(input logic [7:0] b);
        if (run_bytes.size() < 12)
            run_bytes = {run_bytes, b};
    endfunction

    function automatic void emit_rep();
        emit(usan_pkg::REP_B0);
        emit(usan_pkg::REP_B1);
        emit(usan_pkg::REP_B2);
    endfunction

    function automatic void seq_clear();
        seq_len = usan_pkg::LEN_NONE;
        seq_cnt = 2'd0;
        for (int k = 0; k < 3; k++)
            seq_hold[k] = 8'h00;
    endfunction

    function automatic void seq_flush();
        for (int k = 0; k < int'(seq_cnt); k++)
            emit_rep();
        seq_clear();
    endfunction

    // Decode the held bytes plus the final one and pass or replace them all
    function automatic void seq_close(input logic [7:0] last);
        logic [7:0]  full [4];
        int          n;
        logic [20:0] cp;
        logic        reject;
        n = int'(seq_len);
        for (int k = 0; k < n - 1; k++)
            full[k] = seq_hold[k];
        full[n - 1] = last;
        case (seq_len)
            usan_pkg::LEN_2: cp = 21'(full[0][4:0]);
            usan_pkg::LEN_3: cp = 21'(full[0][3:0]);
            default:         cp = 21'(full[0][2:0]);
        endcase
        for (int k = 1; k < n; k++)
            cp = (cp << 6) | 21'(full[k][5:0]);
        reject = (seq_len == usan_pkg::LEN_2 && cp < usan_pkg::CP_MIN_2B) ||
                 (seq_len == usan_pkg::LEN_3 && cp < usan_pkg::CP_MIN_3B) ||
                 (seq_len == usan_pkg::LEN_4 && cp < usan_pkg::CP_MIN_4B) ||
                 cp > usan_pkg::CP_MAX ||
                 (cp >= usan_pkg::SURR_LO && cp <= usan_pkg::SURR_HI);
        for (int k = 0; k < n; k++)
        begin
            if (reject)
                emit_rep();
            else
                emit(full[k]);
        end
        seq_clear();
    endfunction

    function automatic void seq_open(input logic [7:0] b, input logic [2:0] len);
        seq_hold[0] = b;
        seq_cnt     = 2'd1;
        seq_len     = len;
    endfunction

    function automatic void scan_byte(input logic [7:0] b);
        if (seq_len != usan_pkg::LEN_NONE)
        begin
            if (b[7:6] == 2'b10)
            begin
                if (int'(seq_cnt) + 1 >= int'(seq_len) || seq_cnt == 2'd3)
                begin
                    seq_close(b);
                end
                else
                begin
                    seq_hold[seq_cnt] = b;
                    seq_cnt = seq_cnt + 2'd1;
                end
                return;
            end
            // Non-continuation interrupts: replace held, then rescan this byte
            seq_flush();
        end
        if (!b[7])
            emit(b);
        else if (b[7:5] == 3'b110)
            seq_open(b, usan_pkg::LEN_2);
        else if (b[7:4] == 4'b1110)
            seq_open(b, usan_pkg::LEN_3);
        else if (b[7:3] == 5'b11110)
            seq_open(b, usan_pkg::LEN_4);
        else
            emit_rep();
    endfunction

    function automatic void predict_bytes(input usan_pkg::in_word_t w);
        run_bytes.delete();
        scan_byte(w.in_byte);
        if (w.end_of_stream)
            seq_flush();
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic void queue_byte(input logic [7:0] b);
        usan_pkg::in_word_t w;
        w.in_byte       = b;
        w.end_of_stream = 1'b0;
        pending = {pending, w};
    endfunction

    function automatic void mark_eos();
        usan_pkg::in_word_t w;
        w = pending[pending.size() - 1];
        w.end_of_stream = 1'b1;
        pending[pending.size() - 1] = w;
    endfunction

    // Queue the first keep bytes of a len-byte encoding of cp
    function automatic void queue_code(input int len, input logic [20:0] cp,
                                       input int keep);
        logic [7:0] b [4];
        case (len)
            2:       b[0] = {3'b110, cp[10:6]};
            3:       b[0] = {4'b1110, cp[15:12]};
            default: b[0] = {5'b11110, cp[20:18]};
        endcase
        for (int k = 1; k < len; k++)
            b[k] = {2'b10, cp[6 * (len - 1 - k) +: 6]};
        for (int k = 0; k < keep; k++)
            queue_byte(b[k]);
    endfunction

    // Random scalar value that is legal for a len-byte form
    function automatic logic [20:0] pick_code(input int len);
        case (len)
            2: return 21'($urandom_range(32'h7FF, 32'h80));
            3:
            begin
                if ($urandom_range(0, 1) == 0)
                    return 21'($urandom_range(32'hD7FF, 32'h800));
                return 21'($urandom_range(32'hFFFF, 32'hE000));
            end
            default: return 21'($urandom_range(32'h10FFFF, 32'h10000));
        endcase
    endfunction

    // One random group: mostly well-formed sequences, some malformed, some noise
    function automatic void make_group();
        int pick;
        int len;
        int n;
        pick = $urandom_range(0, 99);
        len  = $urandom_range(2, 4);
        if (pick < 20)
        begin
            n = $urandom_range(1, 4);
            repeat (n) queue_byte(8'($urandom_range(8'h7F, 8'h00)));
        end
        else if (pick < 35)
        begin
            queue_code(2, pick_code(2), 2);
        end
        else if (pick < 50)
        begin
            queue_code(3, pick_code(3), 3);
        end
        else if (pick < 63)
        begin
            queue_code(4, pick_code(4), 4);
        end
        else if (pick < 68)
        begin
            // overlong form
            case (len)
                2:       queue_code(2, 21'($urandom_range(32'h7F, 0)), 2);
                3:       queue_code(3, 21'($urandom_range(32'h7FF, 0)), 3);
                default: queue_code(4, 21'($urandom_range(32'hFFFF, 0)), 4);
            endcase
        end
        else if (pick < 72)
        begin
            queue_code(3, 21'($urandom_range(32'hDFFF, 32'hD800)), 3);
        end
        else if (pick < 76)
        begin
            // above 10FFFF, leads F4..F7
            queue_code(4, 21'($urandom_range(32'h1FFFFF, 32'h110000)), 4);
        end
        else if (pick < 84)
        begin
            // cut short by another byte or by end of stream
            queue_code(len, pick_code(len), $urandom_range(1, len - 1));
            case ($urandom_range(0, 3))
                0:       queue_byte(8'($urandom_range(8'h7F, 8'h00)));
                1:       queue_byte(8'($urandom_range(8'hF4, 8'hC2)));
                2:       queue_byte(8'($urandom_range(8'hFF, 8'hF8)));
                default: mark_eos();
            endcase
        end
        else if (pick < 90)
        begin
            n = $urandom_range(1, 3);
            repeat (n) queue_byte(8'($urandom_range(8'hBF, 8'h80)));
        end
        else
        begin
            n = $urandom_range(1, 3);
            repeat (n) queue_byte(8'($urandom_range(255, 0)));
        end
        if ($urandom_range(0, 11) == 0)
            mark_eos();
    endfunction

    // Offer one word, wait for the handshake, then record what it must produce
    task automatic offer(input usan_pkg::in_word_t w, input logic gold_on,
                         input logic [1:0] gold_n, input logic [23:0] gold);
        int                  gap;
        usan_pkg::out_word_t ow;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data  <= w;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        words_in++;
        if (w.end_of_stream)
            eos_count++;
        predict_bytes(w);
        if (gold_on)
        begin
            run_bytes.delete();
            for (int k = 0; k < int'(gold_n); k++)
                run_bytes = {run_bytes, gold[23 - 8 * k -: 8]};
        end
        foreach (run_bytes[k])
        begin
            ow.out_byte = run_bytes[k];
            ow.run_last = (k == run_bytes.size() - 1);
            exp_q = {exp_q, ow};
        end
    endtask

    task automatic wait_drained();
        while (exp_q.size() != 0)
            @(posedge clk);
    endtask

    // ---------------- receiver side ----------------

    initial
    begin : rx_side
        int n;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_hold)
            begin
                // long hold-off so the block fills and stalls its input
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                rx_hold = 1'b0;
                out_ready <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(1, 4);
                out_ready <= 1'b0;
                repeat (n) @(negedge clk);
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // ---------------- output check ----------------

    always @(posedge clk)
    begin : check_out
        usan_pkg::out_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (exp_q.size() == 0)
            begin
                $error("word %h arrived with none expected", out_data);
                errors++;
            end
            else
            begin
                want = exp_q.pop_front();
                words_out++;
                if (out_data.out_byte !== want.out_byte)
                begin
                    $error("out_byte: expected %h, got %h",
                           want.out_byte, out_data.out_byte);
                    errors++;
                end
                if (out_data.run_last !== want.run_last)
                begin
                    $error("run_last: expected %b, got %b",
                           want.run_last, out_data.run_last);
                    errors++;
                end
            end
        end
    end

    // ---------------- main sequence ----------------

    initial
    begin : stimulus
        usan_pkg::in_word_t w;
        int                 sent;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        idle_on   = 1'b1;
        rx_hold   = 1'b0;
        errors    = 0;
        words_in  = 0;
        words_out = 0;
        eos_count = 0;
        sent      = 0;
        seq_clear();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table
        foreach (dir_tab[i])
        begin
            w.in_byte       = dir_tab[i].b;
            w.end_of_stream = dir_tab[i].eos;
            offer(w, dir_tab[i].gold_on, dir_tab[i].gold_n, dir_tab[i].gold);
        end

        // Receiver holds off while back-to-back rejected 4-byte runs keep coming
        rx_hold = 1'b1;
        idle_on = 1'b0;
        repeat (8) queue_code(4, 21'($urandom_range(32'h1FFFFF, 32'h110000)), 4);
        while (pending.size() != 0)
        begin
            offer(pending.pop_front(), 1'b0, 2'd0, 24'h0);
            sent++;
        end
        idle_on = 1'b1;

        // Random streams
        while (sent < RANDOM_WORDS)
        begin
            if (sent == RANDOM_WORDS / 2)
            begin
                // sender pauses until all output is out
                @(negedge clk);
                in_valid <= 1'b0;
                wait_drained();
            end
            if (sent == RANDOM_WORDS - CALM_WORDS)
                idle_on = 1'b0;
            if (pending.size() == 0)
                make_group();
            offer(pending.pop_front(), 1'b0, 2'd0, 24'h0);
            sent++;
        end

        @(negedge clk);
        in_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d input words (%0d end-of-stream marks), %0d output words,",
                 words_in, eos_count, words_out);
        $display("with a long output hold-off, a full drain pause and random idling.");
        if (errors == 0 && exp_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog
    initial
    begin : watchdog
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
